FILE: design/vtp_pkg.sv
// Package for the vector tensor product engine: shared sizes, codes, the cell
// command word and the Q1.15 rounding multiply.
// No dependencies; used by vtp_cell and vector_tensor_product_engine.
package vtp_pkg;

    // Fixed sizes of the block.
    localparam int NUM_FACTORS = 4;
    localparam int LEN_DEPTH   = 64;
    localparam int SAMPLE_W    = 16;
    localparam int ADDR_W      = 6;
    localparam int LEN_W       = 7;
    localparam int FCNT_W      = 3;
    localparam int FSEL_W      = 2;
    localparam int CNT_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Operation codes of an input word.
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTOR_COUNT = 3'd0,
        CFG_LENGTH_ZERO  = 3'd1,
        CFG_LENGTH_ONE   = 3'd2,
        CFG_LENGTH_TWO   = 3'd3,
        CFG_LENGTH_THREE = 3'd4
    } t_cfg_idx;

    // Command word that the top level sends to each cell.
    typedef struct packed {
        logic                start;   // emit word accepted: read element, step digit
        logic                wrap;    // final product of the run: clear the digit
        logic                active;  // cell takes part in the product
        logic                head;    // first cell of the chain
        logic                wr_en;   // load word for this cell
        logic [ADDR_W-1:0]   wr_addr;
        t_sample             wr_data;
    } t_cell_cmd;

    // Q1.15 multiply, add half an LSB, floor, saturate the one overflow.
    function automatic t_sample mul_round(input t_sample a, input t_sample b);
        logic signed [2*SAMPLE_W-1:0] prod;
        logic signed [SAMPLE_W:0]     q;
        prod = a * b;
        prod = prod + (2*SAMPLE_W)'(1 << (SAMPLE_W - 2));
        q    = prod[2*SAMPLE_W-1:SAMPLE_W-1];
        if (!q[SAMPLE_W] && q[SAMPLE_W-1]) begin
            mul_round = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            mul_round = q[SAMPLE_W-1:0];
        end
    endfunction

endpackage

FILE: design/vtp_cell.sv
// One cell of the product chain: element memory of one factor vector, its
// odometer digit, and one rounding multiplier for the running product.
// Depends on vtp_pkg.
module vtp_cell
    import vtp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_cmd         i_cmd,
    input  logic [LEN_W-1:0]  i_length,
    input  logic              i_carry,
    output logic              o_carry,
    input  t_sample           i_part,
    input  logic              i_pvld,
    output t_sample           o_part,
    output logic              o_pvld
);

    t_sample             r_mem [LEN_DEPTH];
    t_sample             r_elem;
    t_sample             r_part;
    t_sample             n_part;
    logic                r_pvld;
    logic [ADDR_W-1:0]   r_digit;
    logic [ADDR_W-1:0]   n_digit;
    logic                w_at_end;

    // Element memory: written by load words, read at the digit on an emit word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.start) begin
            r_elem <= r_mem[r_digit];
        end
    end

    // The digit sits on its last value when one more step reaches the length.
    assign w_at_end = (LEN_W'(r_digit) + LEN_W'(1)) >= i_length;
    assign o_carry  = i_cmd.active ? (i_carry & w_at_end) : i_carry;

    // Odometer step: a carry from the faster cells advances or wraps this digit.
    always_comb begin
        n_digit = r_digit;
        if (i_cmd.start) begin
            if (i_cmd.wrap) begin
                n_digit = '0;
            end else if (i_cmd.active && i_carry) begin
                n_digit = w_at_end ? '0 : r_digit + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
            r_pvld  <= 1'b0;
        end else begin
            r_digit <= n_digit;
            r_pvld  <= i_pvld & i_cmd.active;
        end
    end

    // Running product: the head cell starts it, every other cell multiplies in.
    assign n_part = i_cmd.head ? r_elem : mul_round(i_part, r_elem);

    always_ff @(posedge i_clk) begin
        if (i_pvld) begin
            r_part <= n_part;
        end
    end

    assign o_part = r_part;
    assign o_pvld = r_pvld;

endmodule

FILE: design/vector_tensor_product_engine.sv
// Vector tensor product engine: Kronecker product of up to four Q1.15 vectors.
// Depends on vtp_pkg and vtp_cell.
//
// A load word writes one element into the memory of the cell that owns its
// factor and does not hold off the input. An emit word steps a mixed-radix
// odometer whose digits live in a chain of four cells; the running product
// then walks down the chain, one cell and one rounding multiply per cycle.
// The result passes through the product registers of the active cells into
// the output register, and the next word is taken in the cycle after that.
// A result that meets a full, held output register waits at the end of the
// chain and holds off the input for as long as the output is held. A
// finished word waiting at the output does not block the input. Flat indexes
// count up from zero and wrap after the word marked last.
module vector_tensor_product_engine
    import vtp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_operation,
    input  logic [FSEL_W-1:0]      i_factor,
    input  logic [ADDR_W-1:0]      i_position,
    input  logic signed [SAMPLE_W-1:0] i_element_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_product,
    output logic [CNT_W-1:0]       o_flat_index,
    output logic                   o_last
);

    logic [FCNT_W-1:0]  r_fcount;
    logic [LEN_W-1:0]   r_len [NUM_FACTORS];
    logic [LEN_W-1:0]   w_len [NUM_FACTORS];
    logic [FCNT_W-1:0]  w_nfac;

    logic               w_in_acc;
    logic               w_emit;
    logic               w_load;
    logic               w_last;
    logic               w_fin;
    logic               w_have;
    logic               w_out_free;

    logic               r_busy;
    logic               r_go;
    logic               r_pend;
    logic [FSEL_W-1:0]  r_sel;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_idx;
    logic               r_last_q;

    logic               r_out_vld;
    t_sample            r_prod;
    logic [CNT_W-1:0]   r_out_idx;
    logic               r_out_last;

    t_cell_cmd          w_cmd   [NUM_FACTORS];
    logic               w_carry [NUM_FACTORS+1];
    t_sample            w_part  [NUM_FACTORS];
    logic               w_pvld  [NUM_FACTORS];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcount <= FCNT_W'(1);
            for (int k = 0; k < NUM_FACTORS; k++) begin
                r_len[k] <= LEN_W'(1);
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FACTOR_COUNT: r_fcount <= i_cfg_data[FCNT_W-1:0];
                CFG_LENGTH_ZERO:  r_len[0] <= i_cfg_data[LEN_W-1:0];
                CFG_LENGTH_ONE:   r_len[1] <= i_cfg_data[LEN_W-1:0];
                CFG_LENGTH_TWO:   r_len[2] <= i_cfg_data[LEN_W-1:0];
                CFG_LENGTH_THREE: r_len[3] <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the factor count and the lengths into their legal ranges.
    always_comb begin
        if (r_fcount == '0) begin
            w_nfac = FCNT_W'(1);
        end else if (r_fcount > FCNT_W'(NUM_FACTORS)) begin
            w_nfac = FCNT_W'(NUM_FACTORS);
        end else begin
            w_nfac = r_fcount;
        end
        for (int k = 0; k < NUM_FACTORS; k++) begin
            if (r_len[k] == '0) begin
                w_len[k] = LEN_W'(1);
            end else if (r_len[k] > LEN_W'(LEN_DEPTH)) begin
                w_len[k] = LEN_W'(LEN_DEPTH);
            end else begin
                w_len[k] = r_len[k];
            end
        end
    end

    // Input handshake: one word in flight until its result is registered.
    assign o_in_ready = !r_busy;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_emit     = w_in_acc && (t_op'(i_operation) == OP_EMIT);
    assign w_load     = w_in_acc && (t_op'(i_operation) == OP_LOAD);

    // The carry runs from the last cell toward cell 0; out of cell 0 it marks
    // the final product of the run.
    assign w_carry[NUM_FACTORS] = 1'b1;
    assign w_last               = w_carry[0];

    // Cell chain.
    for (genvar g = 0; g < NUM_FACTORS; g++) begin : g_cell
        always_comb begin
            w_cmd[g].start   = w_emit;
            w_cmd[g].wrap    = w_last;
            w_cmd[g].active  = FCNT_W'(g) < w_nfac;
            w_cmd[g].head    = (g == 0);
            w_cmd[g].wr_en   = w_load && (i_factor == FSEL_W'(g));
            w_cmd[g].wr_addr = i_position;
            w_cmd[g].wr_data = i_element_value;
        end

        if (g == 0) begin : g_head
            vtp_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_cmd    (w_cmd[g]),
                .i_length (w_len[g]),
                .i_carry  (w_carry[g+1]),
                .o_carry  (w_carry[g]),
                .i_part   ('0),
                .i_pvld   (r_go),
                .o_part   (w_part[g]),
                .o_pvld   (w_pvld[g])
            );
        end else begin : g_body
            vtp_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_cmd    (w_cmd[g]),
                .i_length (w_len[g]),
                .i_carry  (w_carry[g+1]),
                .o_carry  (w_carry[g]),
                .i_part   (w_part[g-1]),
                .i_pvld   (w_pvld[g-1]),
                .o_part   (w_part[g]),
                .o_pvld   (w_pvld[g])
            );
        end
    end

    // Flat index counter wraps after the final product.
    assign n_count = w_last ? '0 : r_count + CNT_W'(1);

    // The product is done when the last active cell shows a valid value.
    assign w_fin      = w_pvld[r_sel];
    assign w_have     = r_busy && (w_fin || r_pend);
    assign w_out_free = !r_out_vld || i_out_ready;

    // Word control and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_go       <= 1'b0;
            r_pend     <= 1'b0;
            r_sel      <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_last_q   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_out_idx  <= '0;
            r_out_last <= 1'b0;
        end else begin
            r_go <= w_emit;
            if (w_emit) begin
                r_busy   <= 1'b1;
                r_sel    <= FSEL_W'(w_nfac - FCNT_W'(1));
                r_idx    <= r_count;
                r_last_q <= w_last;
                r_count  <= n_count;
            end
            if (w_have && w_out_free) begin
                r_out_vld  <= 1'b1;
                r_out_idx  <= r_idx;
                r_out_last <= r_last_q;
                r_busy     <= 1'b0;
                r_pend     <= 1'b0;
            end else begin
                if (i_out_ready) begin
                    r_out_vld <= 1'b0;
                end
                if (r_busy && w_fin) begin
                    r_pend <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_have && w_out_free) begin
            r_prod <= w_part[r_sel];
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_product    = r_prod;
    assign o_flat_index = r_out_idx;
    assign o_last       = r_out_last;

    // An emit word closes the input until its result is registered.
    a_emit_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_busy && !o_in_ready))
        else $error("emit word did not hold off the input");

    // The flat index restarts after the final product of a run.
    a_index_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_count == '0))
        else $error("flat index did not restart after the last product");

    // Handing a finished product to the output frees the chain.
    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_have && w_out_free) |=> (o_out_valid && !r_busy && !r_pend))
        else $error("finished product not delivered to the output");

endmodule
